### sv/tbcc_pkg.sv
// Shared types and constants of the time-bin coverage classifier.
// Holds the item structs, configuration struct, command/status structs and codes.
// Depends on nothing.
`default_nettype none

package tbcc_pkg;

    // Widths fixed by the item and register formats
    localparam int TS_W       = 64;
    localparam int CONF_W     = 16;
    localparam int CONF_WIDTH = 16;   // confidence bits taken part in the threshold compare
    localparam int BIN_CNT_W  = 7;
    localparam int BIN_IDX_W  = 6;
    localparam int REM_W      = 6;
    localparam int TOL_W      = 63;
    localparam int CLASS_W    = 2;

    localparam int MAX_BINS_DEF = 64;

    // Bit-serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = TS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register port
    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;
    localparam int REG_ADDR_LSB = 3;
    localparam int REG_IDX_W    = APB_ADDR_W - REG_ADDR_LSB;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WINDOW_START   = 3'd0,
        REG_WINDOW_END     = 3'd1,
        REG_BIN_COUNT      = 3'd2,
        REG_GAP_TOLERANCE  = 3'd3,
        REG_CONF_THRESHOLD = 3'd4
    } t_reg_idx;

    localparam logic [TS_W-1:0]      RST_WINDOW_START   = 64'd0;
    localparam logic [TS_W-1:0]      RST_WINDOW_END     = 64'd1000000;
    localparam logic [BIN_CNT_W-1:0] RST_BIN_COUNT      = 7'd64;
    localparam logic [TOL_W-1:0]     RST_GAP_TOLERANCE  = 63'd100000;
    localparam logic [CONF_W-1:0]    RST_CONF_THRESHOLD = 16'd32768;

    // Bin classes
    localparam logic [CLASS_W-1:0] CLS_PRESENT  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_LOW_CONF = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_GAP      = 2'd2;

    // Input opcodes
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_END_LANE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [TS_W-1:0]   timestamp;
        logic [CONF_W-1:0] confidence;
        logic              conf_valid;
    } t_in_item;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [CLASS_W-1:0]   bin_class;
        logic                 run_last;
        logic                 lane_done;
    } t_out_item;

    typedef struct packed {
        logic [TS_W-1:0]      window_start;
        logic [TS_W-1:0]      window_end;
        logic [BIN_CNT_W-1:0] bin_count;
        logic [TOL_W-1:0]     gap_tolerance;
        logic [CONF_W-1:0]    conf_threshold;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic div_load;
        logic div_step;
        logic lane_init;
        logic prime;
        logic take_item;
        logic close_emit;
        logic sample_finish;
        logic flush_emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic close_now;
        logic more;
        logic bins_left;
        logic last_bin;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### sv/tbcc_regs.sv
// Configuration register file with APB-style access.
// Uses tbcc_pkg for the register map, reset values and t_cfg.
`default_nettype none

module tbcc_regs (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [tbcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [tbcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tbcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output tbcc_pkg::t_cfg                      o_cfg,
    output logic                                o_cfg_wr
);

    tbcc_pkg::t_cfg   r_cfg;
    tbcc_pkg::t_reg_idx reg_idx;
    logic             wr_beat;

    assign pready  = 1'b1;
    assign reg_idx = tbcc_pkg::t_reg_idx'(paddr[tbcc_pkg::APB_ADDR_W-1:tbcc_pkg::REG_ADDR_LSB]);
    assign wr_beat = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start   <= tbcc_pkg::RST_WINDOW_START;
            r_cfg.window_end     <= tbcc_pkg::RST_WINDOW_END;
            r_cfg.bin_count      <= tbcc_pkg::RST_BIN_COUNT;
            r_cfg.gap_tolerance  <= tbcc_pkg::RST_GAP_TOLERANCE;
            r_cfg.conf_threshold <= tbcc_pkg::RST_CONF_THRESHOLD;
        end else if (wr_beat) begin
            unique case (reg_idx)
                tbcc_pkg::REG_WINDOW_START:   r_cfg.window_start <= pwdata;
                tbcc_pkg::REG_WINDOW_END:     r_cfg.window_end   <= pwdata;
                tbcc_pkg::REG_BIN_COUNT:
                    r_cfg.bin_count <= pwdata[tbcc_pkg::BIN_CNT_W-1:0];
                tbcc_pkg::REG_GAP_TOLERANCE:
                    r_cfg.gap_tolerance <= pwdata[tbcc_pkg::TOL_W-1:0];
                tbcc_pkg::REG_CONF_THRESHOLD:
                    r_cfg.conf_threshold <= pwdata[tbcc_pkg::CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // Restart the lane only on a write that hits a register
    always_comb begin
        o_cfg_wr = 1'b0;
        prdata   = '0;
        unique case (reg_idx)
            tbcc_pkg::REG_WINDOW_START: begin
                o_cfg_wr = wr_beat;
                prdata   = r_cfg.window_start;
            end
            tbcc_pkg::REG_WINDOW_END: begin
                o_cfg_wr = wr_beat;
                prdata   = r_cfg.window_end;
            end
            tbcc_pkg::REG_BIN_COUNT: begin
                o_cfg_wr = wr_beat;
                prdata   = tbcc_pkg::APB_DATA_W'(r_cfg.bin_count);
            end
            tbcc_pkg::REG_GAP_TOLERANCE: begin
                o_cfg_wr = wr_beat;
                prdata   = tbcc_pkg::APB_DATA_W'(r_cfg.gap_tolerance);
            end
            tbcc_pkg::REG_CONF_THRESHOLD: begin
                o_cfg_wr = wr_beat;
                prdata   = tbcc_pkg::APB_DATA_W'(r_cfg.conf_threshold);
            end
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/tbcc_ctrl.sv
// Sequencer of the classifier: divider run, lane set-up, sample and end-of-lane handling.
// Uses tbcc_pkg for t_cmd, t_status and the opcodes.
`default_nettype none

module tbcc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_wr,
    input  wire               i_in_valid,
    input  wire               i_in_opcode,
    input  tbcc_pkg::t_status i_status,
    output logic              o_in_stall,
    output tbcc_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        ST_DIV_LOAD  = 7'b0000001,
        ST_DIV_STEP  = 7'b0000010,
        ST_LANE_INIT = 7'b0000100,
        ST_PRIME     = 7'b0001000,
        ST_IDLE      = 7'b0010000,
        ST_CLOSE     = 7'b0100000,
        ST_FLUSH     = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [tbcc_pkg::DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        unique case (r_state)
            ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = '0;
                n_state        = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == tbcc_pkg::DIV_CNT_W'(tbcc_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_LANE_INIT;
                end
            end
            ST_LANE_INIT: begin
                o_cmd.lane_init = 1'b1;
                n_state         = ST_PRIME;
            end
            ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state = (i_in_opcode == tbcc_pkg::OP_END_LANE) ? ST_FLUSH : ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (i_status.close_now) begin
                    if (i_status.out_free) begin
                        o_cmd.close_emit = 1'b1;
                        if (!i_status.more) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    o_cmd.sample_finish = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_status.bins_left) begin
                    if (i_status.out_free) begin
                        o_cmd.flush_emit = 1'b1;
                        if (i_status.last_bin) begin
                            n_state = ST_LANE_INIT;
                        end
                    end
                end else begin
                    n_state = ST_LANE_INIT;
                end
            end
            default: n_state = ST_DIV_LOAD;
        endcase
        // A register write redoes the division and restarts the lane
        if (i_cfg_wr) begin
            n_state = ST_DIV_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_DIV_LOAD;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> (r_state == ST_DIV_LOAD))
        else $error("register write did not restart the divider");

endmodule

`default_nettype wire

### sv/tbcc_dp.sv
// Datapath of the classifier: divider, bin edge stepping, bin flags and output register.
// Uses tbcc_pkg for item, configuration, command and status types.
`default_nettype none

module tbcc_dp #(
    parameter int MAX_BINS = tbcc_pkg::MAX_BINS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  tbcc_pkg::t_cfg        i_cfg,
    input  tbcc_pkg::t_cmd        i_cmd,
    input  tbcc_pkg::t_in_item    i_in_data,
    input  wire                   i_out_stall,
    output tbcc_pkg::t_status     o_status,
    output logic                  o_out_valid,
    output tbcc_pkg::t_out_item   o_out_data
);

    localparam int TS_W   = tbcc_pkg::TS_W;
    localparam int CNT_W  = tbcc_pkg::BIN_CNT_W;
    localparam int REM_W  = tbcc_pkg::REM_W;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_BINS);

    // Held item
    logic [TS_W-1:0]            r_t;
    logic [tbcc_pkg::CONF_W-1:0] r_conf;
    logic                       r_conf_valid;

    // Lane state
    logic [CNT_W-1:0] r_cur, r_nbins;
    logic             r_has, r_low, r_have_prev, r_span_empty;
    logic [TS_W-1:0]  r_prev, r_bin_lo, r_nb, r_nb2;
    logic [REM_W-1:0] r_rem2;

    // Divider: quotient shifts into r_div_num, which then holds the bin width
    logic [TS_W-1:0]  r_div_num;
    logic [REM_W-1:0] r_div_rem;

    logic                    r_out_valid;
    tbcc_pkg::t_out_item     r_out_data, n_out;

    logic [CNT_W-1:0] cur_inc, n_nbins, rem_diff;
    logic [REM_W:0]   rem_sum, div_trial, div_diff;
    logic [REM_W-1:0] n_rem2;
    logic [TS_W-1:0]  nb2_adv, first_edge, dt;
    logic cur_in, nxt_in, last_bin, carry, div_qbit;
    logic t_ge_nb, t_ge_nb2, t_ge_lo, sample_low, gap_far, more, close_now, emit;

    assign cur_inc  = r_cur + 1'b1;
    assign cur_in   = (r_cur < r_nbins);
    assign nxt_in   = (cur_inc < r_nbins);
    assign last_bin = (cur_inc == r_nbins);

    assign t_ge_nb  = ($signed(r_t) >= $signed(r_nb));
    assign t_ge_nb2 = ($signed(r_t) >= $signed(r_nb2));
    assign t_ge_lo  = ($signed(r_t) >= $signed(r_bin_lo));

    assign sample_low = r_conf_valid &&
        (r_conf[tbcc_pkg::CONF_WIDTH-1:0] < i_cfg.conf_threshold[tbcc_pkg::CONF_WIDTH-1:0]);
    assign dt      = r_t - r_prev;
    assign gap_far = (dt > {1'b0, i_cfg.gap_tolerance});

    assign close_now = !r_span_empty && cur_in && t_ge_nb;
    assign more      = nxt_in && t_ge_nb2;

    // Edge stepping: width plus carried fraction of the remainder
    assign rem_sum  = {1'b0, r_rem2} + {1'b0, r_div_rem};
    assign carry    = (rem_sum >= r_nbins);
    assign rem_diff = rem_sum - r_nbins;
    assign n_rem2   = carry ? rem_diff[REM_W-1:0] : rem_sum[REM_W-1:0];
    assign nb2_adv  = r_nb2 + r_div_num + TS_W'(carry);
    assign first_edge = i_cfg.window_start + r_div_num;

    assign div_trial = {r_div_rem, r_div_num[TS_W-1]};
    assign div_qbit  = (div_trial >= r_nbins);
    assign div_diff  = div_trial - r_nbins;

    assign n_nbins = (i_cfg.bin_count == '0 || i_cfg.bin_count > MAX_N) ?
                     MAX_N : i_cfg.bin_count;

    assign emit = i_cmd.close_emit || i_cmd.flush_emit;

    always_comb begin
        n_out.bin_index = r_cur[tbcc_pkg::BIN_IDX_W-1:0];
        n_out.lane_done = last_bin;
        if (r_has) begin
            n_out.bin_class = r_low ? tbcc_pkg::CLS_LOW_CONF : tbcc_pkg::CLS_PRESENT;
        end else if (i_cmd.flush_emit || !r_have_prev || gap_far) begin
            n_out.bin_class = tbcc_pkg::CLS_GAP;
        end else begin
            n_out.bin_class = tbcc_pkg::CLS_PRESENT;
        end
        n_out.run_last = i_cmd.flush_emit ? last_bin : !more;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_has        <= 1'b0;
            r_low        <= 1'b0;
            r_have_prev  <= 1'b0;
            r_span_empty <= 1'b1;
            r_nbins      <= MAX_N;
        end else begin
            priority if (i_cmd.div_load) begin
                r_span_empty <= !($signed(i_cfg.window_end) > $signed(i_cfg.window_start));
                r_nbins      <= n_nbins;
            end else if (i_cmd.lane_init) begin
                r_cur       <= '0;
                r_has       <= 1'b0;
                r_low       <= 1'b0;
                r_have_prev <= 1'b0;
            end else if (emit) begin
                r_cur <= cur_inc;
                if (i_cmd.close_emit && !more) begin
                    // Last bin this sample closes: mark the bin it lands in
                    r_has       <= nxt_in;
                    r_low       <= nxt_in && sample_low;
                    r_have_prev <= 1'b1;
                end else begin
                    r_has <= 1'b0;
                    r_low <= 1'b0;
                end
            end else if (i_cmd.sample_finish) begin
                if (!r_span_empty && cur_in && t_ge_lo) begin
                    r_has <= 1'b1;
                    if (sample_low) begin
                        r_low <= 1'b1;
                    end
                end
                r_have_prev <= 1'b1;
            end else begin
                r_cur <= r_cur;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_t          <= i_in_data.timestamp;
            r_conf       <= i_in_data.confidence;
            r_conf_valid <= i_in_data.conf_valid;
        end
        if (i_cmd.div_load) begin
            r_div_num <= i_cfg.window_end - i_cfg.window_start;
            r_div_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[TS_W-2:0], div_qbit};
            r_div_rem <= div_qbit ? div_diff[REM_W-1:0] : div_trial[REM_W-1:0];
        end
        if (i_cmd.lane_init) begin
            r_prev   <= '0;
            r_bin_lo <= i_cfg.window_start;
            r_nb     <= first_edge;
            r_nb2    <= first_edge;
            r_rem2   <= r_div_rem;
        end else if (i_cmd.prime) begin
            r_nb2  <= nb2_adv;
            r_rem2 <= n_rem2;
        end else if (emit) begin
            r_bin_lo <= r_nb;
            r_nb     <= r_nb2;
            r_nb2    <= nb2_adv;
            r_rem2   <= n_rem2;
            if (i_cmd.close_emit && !more) begin
                r_prev <= r_t;
            end
        end else if (i_cmd.sample_finish) begin
            r_prev <= r_t;
        end
        if (emit) begin
            r_out_data <= n_out;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;
    assign o_status.close_now = close_now;
    assign o_status.more      = more;
    assign o_status.bins_left = cur_in;
    assign o_status.last_bin  = last_bin;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit)
        else $error("result loaded over a stalled beat");

    a_bin_in_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_cur < r_nbins))
        else $error("bin reported beyond the lane");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_out.lane_done) |=> (o_out_valid && o_out_data.run_last))
        else $error("final bin of lane not flagged as last of its item");

endmodule

`default_nettype wire

### sv/time_bin_coverage_classifier_top.sv
// Time-bin coverage classifier, top level; instantiates tbcc_regs, tbcc_ctrl, tbcc_dp.
// A sample item gives one result for each bin it closes; an end-of-lane item flushes the
// bins left. The next item is taken only once the current one is done.
// After reset and after every register write the block takes no item while
// the bit-serial divider works out the bin width (one quotient bit a cycle) and sets up the lane.
// Reset is synchronous, active low; it restores register defaults and clears the lane.
`default_nettype none

module time_bin_coverage_classifier_top #(
    parameter int MAX_BINS = tbcc_pkg::MAX_BINS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    // Register port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [tbcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [tbcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tbcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,

    // Item channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  tbcc_pkg::t_in_item               i_in_data,

    // Result channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output tbcc_pkg::t_out_item              o_out_data
);

    tbcc_pkg::t_cfg    cfg;
    tbcc_pkg::t_cmd    cmd;
    tbcc_pkg::t_status status;
    logic              cfg_wr;

    // Registers sit at byte address 8*i; a write to one of them restarts the lane
    tbcc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    // Sequencer: divide, set up lane, then one beat a cycle while bins close and the output is free
    tbcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_in_valid  (i_in_valid),
        .i_in_opcode (i_in_data.opcode),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    // Datapath: exact integer bin edges, bin flags, output register
    tbcc_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
